[rtl/core/smcs_pkg.sv]
package smcs_pkg;

   // Request modes carried in tuser
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_FINISH = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   // Response kinds carried in tuser
   localparam logic [1:0] KIND_ACCEPT  = 2'd0;
   localparam logic [1:0] KIND_REJECT  = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;
   localparam logic [1:0] KIND_ENTRY   = 2'd3;

   localparam int IDX_W   = 10;
   localparam int CNT_W   = 13;
   localparam int NUM_W   = 11;
   localparam int DIM_W   = 11;
   localparam int COORD_W = 2 * IDX_W;

   // Summary figures from the finish scan
   typedef struct packed {
      logic [NUM_W-1:0] single_cols;
      logic [NUM_W-1:0] single_rows;
      logic [NUM_W-1:0] half_cols;
      logic [NUM_W-1:0] half_rows;
      logic [CNT_W-1:0] max_col;
      logic [CNT_W-1:0] max_row;
   } summary_type;

   // Response payload, last field in the lowest bits
   typedef struct packed {
      logic [4:0]       pad;
      logic [CNT_W-1:0] ext_col_count;
      logic [CNT_W-1:0] ext_row_count;
      logic [CNT_W-1:0] col_count;
      logic [CNT_W-1:0] row_count;
      logic             extended_present;
      logic [NUM_W-1:0] single_cols;
      logic [NUM_W-1:0] single_rows;
      logic [NUM_W-1:0] half_cols;
      logic [NUM_W-1:0] half_rows;
      logic [CNT_W-1:0] max_col;
      logic [CNT_W-1:0] max_row;
   } rsp_data_type;

endpackage

[rtl/core/sparse_matrix_count_sketch_top.sv]
// Add and read: the request passes through S_ADD or S_READ, then S_OUT; a reject goes to S_OUT.
// Finish: a histogram scan over all MAX_DIM entries; when some row or column repeats, a second
// pass reads each stored coordinate and skips those outside the dimension.
// Clear: zeroes one entry of each histogram per cycle; one item at a time.
// Reset (synchronous, active high) starts a clearing sweep of all MAX_DIM entries of the
// histogram memories during which no request is taken; configuration writes still land.
module sparse_matrix_count_sketch_top #(
   parameter int MAX_DIM      = 1024,
   parameter int MAX_NONZEROS = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // row_index, col_index, query_index, zero pad
   input  logic [1:0]    req_tuser,   // mode
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // max_row, max_col, half_rows, half_cols,
                                      // single_rows, single_cols, extended_present,
                                      // row_count, col_count, ext_row_count,
                                      // ext_col_count, zero pad
   output logic [1:0]    rsp_tuser,   // kind
   input  logic          csr_wr_en,
   input  logic [10:0]   csr_wr_data  // dim_n
);

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int IW = $clog2(MAX_DIM + 1);
   localparam int NW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
   localparam int TW = $clog2(MAX_NONZEROS + 1);
   localparam int CW = TW;
   localparam int XW = (IW > smcs_pkg::DIM_W) ? IW : smcs_pkg::DIM_W;
   localparam int DW = smcs_pkg::DIM_W;
   localparam int QW = smcs_pkg::IDX_W;
   localparam logic [DW-1:0] DIM_CAP = (MAX_DIM > 2047) ? 11'd2047 : DW'(MAX_DIM);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_ADD  = 4'd2;
   localparam logic [3:0] S_READ = 4'd3;
   localparam logic [3:0] S_SCAN = 4'd4;
   localparam logic [3:0] S_X0   = 4'd5;
   localparam logic [3:0] S_X1   = 4'd6;
   localparam logic [3:0] S_X2   = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   // Histogram memories hold {count, extended count}
   logic [2*CW-1:0]               row_mem [MAX_DIM];
   logic [2*CW-1:0]               col_mem [MAX_DIM];
   logic [smcs_pkg::COORD_W-1:0]  crd_mem [MAX_NONZEROS];

   logic [2*CW-1:0] row_q_ff, col_q_ff;
   logic [smcs_pkg::COORD_W-1:0] crd_q_ff;

   logic                         row_we, col_we, crd_we;
   logic [AW-1:0]                row_wa, col_wa, row_ra, col_ra;
   logic [2*CW-1:0]              row_wd, col_wd;
   logic [NW-1:0]                crd_wa, crd_ra;
   logic [smcs_pkg::COORD_W-1:0] crd_wd;

   logic [3:0]     state_ff, state_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           pv_ff, pv_in;
   logic [AW-1:0]  pidx_ff, pidx_in;
   logic [TW-1:0]  total_ff, total_in;
   logic [TW-1:0]  xi_ff, xi_in;
   logic           ext_valid_ff, ext_valid_in;
   logic           clr_reply_ff, clr_reply_in;
   logic [DW-1:0]  dim_ff, dim_in;
   logic [QW-1:0]  xr_ff, xr_in, xc_ff, xc_in;
   logic           q_ok_ff, q_ok_in;
   logic [1:0]     res_kind_ff, res_kind_in;
   smcs_pkg::rsp_data_type res_data_ff, res_data_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_kind_ff, rsp_kind_in;
   smcs_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic [DW-1:0]  dim_use;
   logic [1:0]     req_mode;
   logic [QW-1:0]  req_row, req_col, req_query;
   logic [CW-1:0]  rcnt, rext, ccnt, cext;
   logic [QW-1:0]  st_row, st_col;
   logic           out_free, req_take;
   logic           stat_start, stat_valid, repeat_seen;
   smcs_pkg::summary_type summary;

   // Dimension in use: zero acts as one, clamp to capacity
   always_comb begin
      if (dim_ff == '0) begin
         dim_use = DW'(1);
      end else if (dim_ff > DIM_CAP) begin
         dim_use = DIM_CAP;
      end else begin
         dim_use = dim_ff;
      end
   end

   assign req_mode  = req_tuser;
   assign req_row   = req_tdata[9:0];
   assign req_col   = req_tdata[19:10];
   assign req_query = req_tdata[29:20];
   assign rcnt      = row_q_ff[2*CW-1:CW];
   assign rext      = row_q_ff[CW-1:0];
   assign ccnt      = col_q_ff[2*CW-1:CW];
   assign cext      = col_q_ff[CW-1:0];
   assign st_row    = crd_q_ff[9:0];
   assign st_col    = crd_q_ff[19:10];

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   smcs_scan_stats #(
      .CW (CW),
      .IW (IW)
   ) u_stats (
      .clock       (clock),
      .start       (stat_start),
      .smp_valid   (stat_valid),
      .row_cnt     (rcnt),
      .col_cnt     (ccnt),
      .dim_use     (dim_use),
      .summary     (summary),
      .repeat_seen (repeat_seen)
   );

   // Sequencer: read, modify and write back the histogram memories
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pv_in        = pv_ff;
      pidx_in      = pidx_ff;
      total_in     = total_ff;
      xi_in        = xi_ff;
      ext_valid_in = ext_valid_ff;
      clr_reply_in = clr_reply_ff;
      dim_in       = csr_wr_en ? csr_wr_data : dim_ff;
      xr_in        = xr_ff;
      xc_in        = xc_ff;
      q_ok_in      = q_ok_ff;
      res_kind_in  = res_kind_ff;
      res_data_in  = res_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      row_we = 1'b0;
      col_we = 1'b0;
      crd_we = 1'b0;
      row_wa = '0;
      col_wa = '0;
      row_wd = '0;
      col_wd = '0;
      row_ra = '0;
      col_ra = '0;
      crd_wa = total_ff[NW-1:0];
      crd_wd = {req_col, req_row};
      crd_ra = xi_ff[NW-1:0];
      stat_start = 1'b0;
      stat_valid = 1'b0;

      unique case (state_ff)
         // Zero one entry of each histogram per cycle
         S_CLR: begin
            row_we = 1'b1;
            col_we = 1'b1;
            row_wa = idx_ff[AW-1:0];
            col_wa = idx_ff[AW-1:0];
            idx_in = idx_ff + IW'(1);
            if (idx_ff == IW'(MAX_DIM - 1)) begin
               total_in     = '0;
               ext_valid_in = 1'b0;
               clr_reply_in = 1'b0;
               if (clr_reply_ff) begin
                  res_kind_in = smcs_pkg::KIND_ACCEPT;
                  res_data_in = '0;
                  state_in    = S_OUT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         // Take a request transaction and dispatch on its mode
         S_IDLE: begin
            if (req_take) begin
               res_data_in = '0;
               unique case (req_mode)
                  smcs_pkg::MODE_ADD: begin
                     if (total_ff == TW'(MAX_NONZEROS) ||
                         {1'b0, req_row} >= dim_use ||
                         {1'b0, req_col} >= dim_use) begin
                        res_kind_in = smcs_pkg::KIND_REJECT;
                        state_in    = S_OUT;
                     end else begin
                        row_ra       = AW'(req_row);
                        col_ra       = AW'(req_col);
                        crd_we       = 1'b1;
                        total_in     = total_ff + TW'(1);
                        ext_valid_in = 1'b0;
                        xr_in        = req_row;
                        xc_in        = req_col;
                        state_in     = S_ADD;
                     end
                  end
                  smcs_pkg::MODE_FINISH: begin
                     idx_in     = '0;
                     pv_in      = 1'b0;
                     stat_start = 1'b1;
                     state_in   = S_SCAN;
                  end
                  smcs_pkg::MODE_READ: begin
                     row_ra   = AW'(req_query);
                     col_ra   = AW'(req_query);
                     q_ok_in  = {1'b0, req_query} < dim_use;
                     state_in = S_READ;
                  end
                  smcs_pkg::MODE_CLEAR: begin
                     idx_in       = '0;
                     clr_reply_in = 1'b1;
                     state_in     = S_CLR;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         // Write back incremented row and column counts
         S_ADD: begin
            row_we      = 1'b1;
            col_we      = 1'b1;
            row_wa      = AW'(xr_ff);
            col_wa      = AW'(xc_ff);
            row_wd      = {rcnt + CW'(1), rext};
            col_wd      = {ccnt + CW'(1), cext};
            res_kind_in = smcs_pkg::KIND_ACCEPT;
            state_in    = S_OUT;
         end
         // Return the counts of one index
         S_READ: begin
            res_kind_in                  = smcs_pkg::KIND_ENTRY;
            res_data_in.extended_present = ext_valid_ff;
            if (q_ok_ff) begin
               res_data_in.row_count = smcs_pkg::CNT_W'(rcnt);
               res_data_in.col_count = smcs_pkg::CNT_W'(ccnt);
               if (ext_valid_ff) begin
                  res_data_in.ext_row_count = smcs_pkg::CNT_W'(rext);
                  res_data_in.ext_col_count = smcs_pkg::CNT_W'(cext);
               end
            end
            state_in = S_OUT;
         end
         // Walk every entry: gather statistics, zero extended counts
         S_SCAN: begin
            if (pv_ff) begin
               row_we     = 1'b1;
               col_we     = 1'b1;
               row_wa     = pidx_ff;
               col_wa     = pidx_ff;
               row_wd     = {rcnt, {CW{1'b0}}};
               col_wd     = {ccnt, {CW{1'b0}}};
               stat_valid = XW'(pidx_ff) < XW'(dim_use);
            end
            if (idx_ff != IW'(MAX_DIM)) begin
               row_ra  = idx_ff[AW-1:0];
               col_ra  = idx_ff[AW-1:0];
               pidx_in = idx_ff[AW-1:0];
               pv_in   = 1'b1;
               idx_in  = idx_ff + IW'(1);
            end else begin
               pv_in = 1'b0;
               if (!pv_ff) begin
                  if (repeat_seen) begin
                     xi_in    = '0;
                     state_in = S_X0;
                  end else begin
                     ext_valid_in = 1'b0;
                     res_kind_in  = smcs_pkg::KIND_SUMMARY;
                     res_data_in.max_row     = summary.max_row;
                     res_data_in.max_col     = summary.max_col;
                     res_data_in.half_rows   = summary.half_rows;
                     res_data_in.half_cols   = summary.half_cols;
                     res_data_in.single_rows = summary.single_rows;
                     res_data_in.single_cols = summary.single_cols;
                     res_data_in.extended_present = 1'b0;
                     state_in = S_OUT;
                  end
               end
            end
         end
         // Fetch the next stored coordinate or close the pass
         S_X0: begin
            if (xi_ff == total_ff) begin
               ext_valid_in = 1'b1;
               res_kind_in  = smcs_pkg::KIND_SUMMARY;
               res_data_in.max_row     = summary.max_row;
               res_data_in.max_col     = summary.max_col;
               res_data_in.half_rows   = summary.half_rows;
               res_data_in.half_cols   = summary.half_cols;
               res_data_in.single_rows = summary.single_rows;
               res_data_in.single_cols = summary.single_cols;
               res_data_in.extended_present = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_X1;
            end
         end
         // Skip coordinates outside the dimension, else read both histograms
         S_X1: begin
            xi_in = xi_ff + TW'(1);
            if ({1'b0, st_row} < dim_use && {1'b0, st_col} < dim_use) begin
               row_ra   = AW'(st_row);
               col_ra   = AW'(st_col);
               xr_in    = st_row;
               xc_in    = st_col;
               state_in = S_X2;
            end else begin
               state_in = S_X0;
            end
         end
         // Bump extended counts against single-entry lines
         S_X2: begin
            row_we = 1'b1;
            col_we = 1'b1;
            row_wa = AW'(xr_ff);
            col_wa = AW'(xc_ff);
            row_wd = {rcnt, rext + CW'(ccnt == CW'(1))};
            col_wd = {ccnt, cext + CW'(rcnt == CW'(1))};
            state_in = S_X0;
         end
         // Hand the result to the output register once it is free
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_data_in  = res_data_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memories: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (row_we) row_mem[row_wa] <= row_wd;
      if (col_we) col_mem[col_wa] <= col_wd;
      if (crd_we) crd_mem[crd_wa] <= crd_wd;
      row_q_ff <= row_mem[row_ra];
      col_q_ff <= col_mem[col_ra];
      crd_q_ff <= crd_mem[crd_ra];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         idx_ff       <= '0;
         pv_ff        <= 1'b0;
         total_ff     <= '0;
         ext_valid_ff <= 1'b0;
         clr_reply_ff <= 1'b0;
         dim_ff       <= DW'(1024);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pv_ff        <= pv_in;
         total_ff     <= total_in;
         ext_valid_ff <= ext_valid_in;
         clr_reply_ff <= clr_reply_in;
         dim_ff       <= dim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      xi_ff       <= xi_in;
      xr_ff       <= xr_in;
      xc_ff       <= xc_in;
      q_ok_ff     <= q_ok_in;
      res_kind_ff <= res_kind_in;
      res_data_ff <= res_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/core/smcs_scan_stats.sv]
module smcs_scan_stats #(
   parameter int CW = 13,
   parameter int IW = 11
) (
   input  logic                          clock,
   input  logic                          start,
   input  logic                          smp_valid,
   input  logic [CW-1:0]                 row_cnt,
   input  logic [CW-1:0]                 col_cnt,
   input  logic [smcs_pkg::DIM_W-1:0]    dim_use,
   output smcs_pkg::summary_type         summary,
   output logic                          repeat_seen
);

   localparam int HW = (CW + 1 > smcs_pkg::DIM_W) ? CW + 1 : smcs_pkg::DIM_W;

   logic [CW-1:0] max_row_ff, max_row_in, max_col_ff, max_col_in;
   logic [IW-1:0] half_rows_ff, half_rows_in, half_cols_ff, half_cols_in;
   logic [IW-1:0] single_rows_ff, single_rows_in, single_cols_ff, single_cols_in;
   logic          row_half, col_half;

   // Half-full tests: count * 2 against dimension
   assign row_half = HW'({row_cnt, 1'b0}) >= HW'(dim_use);
   assign col_half = HW'({col_cnt, 1'b0}) >= HW'(dim_use);

   // Accumulate one row and one column per sample
   always_comb begin
      max_row_in     = max_row_ff;
      max_col_in     = max_col_ff;
      half_rows_in   = half_rows_ff;
      half_cols_in   = half_cols_ff;
      single_rows_in = single_rows_ff;
      single_cols_in = single_cols_ff;
      if (start) begin
         max_row_in     = '0;
         max_col_in     = '0;
         half_rows_in   = '0;
         half_cols_in   = '0;
         single_rows_in = '0;
         single_cols_in = '0;
      end else if (smp_valid) begin
         if (row_cnt > max_row_ff) max_row_in = row_cnt;
         if (col_cnt > max_col_ff) max_col_in = col_cnt;
         if (row_half) half_rows_in = half_rows_ff + IW'(1);
         if (col_half) half_cols_in = half_cols_ff + IW'(1);
         if (row_cnt == CW'(1)) single_rows_in = single_rows_ff + IW'(1);
         if (col_cnt == CW'(1)) single_cols_in = single_cols_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      max_row_ff     <= max_row_in;
      max_col_ff     <= max_col_in;
      half_rows_ff   <= half_rows_in;
      half_cols_ff   <= half_cols_in;
      single_rows_ff <= single_rows_in;
      single_cols_ff <= single_cols_in;
   end

   // Truncate to the reported widths
   assign summary.max_row     = smcs_pkg::CNT_W'(max_row_ff);
   assign summary.max_col     = smcs_pkg::CNT_W'(max_col_ff);
   assign summary.half_rows   = smcs_pkg::NUM_W'(half_rows_ff);
   assign summary.half_cols   = smcs_pkg::NUM_W'(half_cols_ff);
   assign summary.single_rows = smcs_pkg::NUM_W'(single_rows_ff);
   assign summary.single_cols = smcs_pkg::NUM_W'(single_cols_ff);
   assign repeat_seen = (max_row_ff > CW'(1)) || (max_col_ff > CW'(1));

endmodule
